@@ hdl/sactr_pkg.sv @@
// shared constants and types for the set-associative tag and replacement unit
package sactr_pkg;

	localparam int DEF_MAX_SETS     = 64;
	localparam int DEF_WAYS         = 8;
	localparam int DEF_ADDRESS_BITS = 48;

	localparam int OFFSET_W = 4;
	localparam int SETB_W   = 3;
	localparam int WAYSU_W  = 4;

	localparam logic [OFFSET_W-1:0] RST_OFFSET_BITS = 4'd6;
	localparam logic [SETB_W-1:0]   RST_SET_BITS    = 3'd0;
	localparam logic [WAYSU_W-1:0]  RST_WAYS_IN_USE = 4'd8;
	localparam logic                RST_POLICY_LRU  = 1'b1;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_OFFSET_BITS = 2'd0,
		REG_SET_BITS    = 2'd1,
		REG_WAYS_IN_USE = 2'd2,
		REG_POLICY_LRU  = 2'd3
	} reg_idx_t;

	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic hit;
		logic grow;
	} upd_status_t;

endpackage

@@ hdl/sactr_set_update.sv @@
// tag compare across the ways of one set and reordering of the row for write-back
module sactr_set_update import sactr_pkg::*; #(
	parameter int WAYS         = DEF_WAYS,
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
	input  logic                                  policy_lru,
	input  logic [$clog2(WAYS+1)-1:0]             ways,
	input  logic [ADDRESS_BITS-1:0]               tag,
	input  logic [WAYS-1:0][ADDRESS_BITS-1:0]     rd_tags,
	input  logic [$clog2(WAYS+1)-1:0]             rd_cnt,
	output logic [WAYS-1:0][ADDRESS_BITS-1:0]     new_tags,
	output logic [$clog2(WAYS+1)-1:0]             new_cnt,
	output upd_status_t                           status
);

	localparam int CNT_W = $clog2(WAYS+1);
	localparam int POS_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [CNT_W-1:0]                 cnt;
	logic [WAYS-1:0]                  match;
	logic [POS_W-1:0]                 pos;
	logic                             hit;
	logic [WAYS-1:0][ADDRESS_BITS-1:0] up_tags;

	assign cnt = (rd_cnt < ways) ? rd_cnt : ways;

	always_comb begin
		for (int j = 0; j < WAYS; j++) begin
			match[j] = (j < int'(cnt)) && (rd_tags[j] == tag);
		end
	end

	assign hit = |match;

	// lowest matching way
	always_comb begin
		pos = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (match[j]) begin
				pos = POS_W'(j);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < WAYS - 1; j++) begin
			up_tags[j] = rd_tags[j+1];
		end
		up_tags[WAYS-1] = tag;
	end

	always_comb begin
		for (int j = 0; j < WAYS; j++) begin
			new_tags[j] = rd_tags[j];
			if (hit) begin
				if (policy_lru) begin
					if (j >= int'(pos) && j + 1 < int'(cnt)) begin
						new_tags[j] = up_tags[j];
					end else if (j == int'(cnt) - 1) begin
						new_tags[j] = tag;
					end
				end
			end else if (cnt < ways) begin
				if (j == int'(cnt)) begin
					new_tags[j] = tag;
				end
			end else begin
				if (j + 1 < int'(ways)) begin
					new_tags[j] = up_tags[j];
				end else if (j == int'(ways) - 1) begin
					new_tags[j] = tag;
				end
			end
		end
	end

	assign new_cnt     = cnt + CNT_W'(1);
	assign status.hit  = hit;
	assign status.grow = !hit && (cnt < ways);

endmodule

@@ hdl/set_assoc_cache_tag_replacement_unit.sv @@
// top level of the set-associative cache tag and replacement unit
//
// Each access has two steps: when the item is accepted, the set's row of tags and its
// fill count are read from the tag memory into registers; then all ways are compared in
// parallel and the reordered row is written back, which waits while the output register
// still holds an unaccepted result; the next item is taken after the write-back.
// A finished result sits in an output register while the next item is accepted. After
// reset the fill-count memory is cleared one row a cycle, all of its rows (64 at the
// default, 2**max(1, floor(log2(MAX_SETS))) in general), before the first item is taken;
// configuration writes are taken throughout.
module set_assoc_cache_tag_replacement_unit import sactr_pkg::*; #(
	parameter int MAX_SETS     = DEF_MAX_SETS,
	parameter int WAYS         = DEF_WAYS,
	parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [PDATA_W-1:0]       pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic                     opcode,
	input  logic [ADDRESS_BITS-1:0]  address,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic                     hit,
	output logic                     memory_read,
	output logic                     memory_write
);

	localparam int SMAX  = $clog2(MAX_SETS + 1) - 1;
	localparam int AW    = (SMAX > 0) ? SMAX : 1;
	localparam int ROWS  = 2 ** AW;
	localparam int CNT_W = $clog2(WAYS + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef logic [WAYS-1:0][ADDRESS_BITS-1:0] tag_row_t;

	state_t state_q;

	logic [OFFSET_W-1:0] offset_bits_q;
	logic [SETB_W-1:0]   set_bits_q;
	logic [WAYSU_W-1:0]  ways_in_use_q;
	logic                policy_lru_q;

	logic [AW-1:0]           clr_q;
	logic [AW-1:0]           set_s1;
	logic [ADDRESS_BITS-1:0] tag_s1;
	logic                    opcode_s1;

	logic rsp_valid_q;
	logic hit_q;
	logic memory_read_q;
	logic memory_write_q;

	tag_row_t         tag_mem [ROWS];
	logic [CNT_W-1:0] cnt_mem [ROWS];
	tag_row_t         rd_tags_q;
	logic [CNT_W-1:0] rd_cnt_q;

	logic [SETB_W-1:0]       s_eff;
	logic [CNT_W-1:0]        w_eff;
	logic [ADDRESS_BITS-1:0] addr_off;
	logic [AW-1:0]           set_mask;
	logic [AW-1:0]           set_idx;
	logic [ADDRESS_BITS-1:0] tag_in;

	logic             accept;
	logic             out_free;
	logic             lookup_go;
	tag_row_t         new_tags;
	logic [CNT_W-1:0] new_cnt;
	upd_status_t      status;
	logic             cnt_we;
	logic [AW-1:0]    cnt_wa;
	logic [CNT_W-1:0] cnt_wd;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= RST_OFFSET_BITS;
			set_bits_q    <= RST_SET_BITS;
			ways_in_use_q <= RST_WAYS_IN_USE;
			policy_lru_q  <= RST_POLICY_LRU;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_OFFSET_BITS: offset_bits_q <= pwdata[OFFSET_W-1:0];
				REG_SET_BITS:    set_bits_q    <= pwdata[SETB_W-1:0];
				REG_WAYS_IN_USE: ways_in_use_q <= pwdata[WAYSU_W-1:0];
				REG_POLICY_LRU:  policy_lru_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[3:2]))
			REG_OFFSET_BITS: prdata = PDATA_W'(offset_bits_q);
			REG_SET_BITS:    prdata = PDATA_W'(set_bits_q);
			REG_WAYS_IN_USE: prdata = PDATA_W'(ways_in_use_q);
			REG_POLICY_LRU:  prdata = PDATA_W'(policy_lru_q);
			default:         prdata = '0;
		endcase
	end

	// effective geometry
	always_comb begin
		s_eff = set_bits_q;
		if (int'(set_bits_q) > SMAX) begin
			s_eff = SETB_W'(SMAX);
		end
	end

	always_comb begin
		w_eff = CNT_W'(ways_in_use_q);
		if (ways_in_use_q == '0) begin
			w_eff = CNT_W'(1);
		end else if (int'(ways_in_use_q) > WAYS) begin
			w_eff = CNT_W'(WAYS);
		end
	end

	assign addr_off = address >> offset_bits_q;
	assign set_mask = AW'((1 << s_eff) - 1);
	assign set_idx  = addr_off[AW-1:0] & set_mask;
	assign tag_in   = address >> (5'(offset_bits_q) + 5'(s_eff));

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign lookup_go = (state_q == ST_LOOKUP) && out_free;

	sactr_set_update #(
		.WAYS         (WAYS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_update (
		.policy_lru (policy_lru_q),
		.ways       (w_eff),
		.tag        (tag_s1),
		.rd_tags    (rd_tags_q),
		.rd_cnt     (rd_cnt_q),
		.new_tags   (new_tags),
		.new_cnt    (new_cnt),
		.status     (status)
	);

	// tag row memory
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			tag_mem[set_s1] <= new_tags;
		end
		if (accept) begin
			rd_tags_q <= tag_mem[set_idx];
		end
	end

	// fill count memory, cleared after reset
	assign cnt_we = (state_q == ST_CLEAR) || (lookup_go && status.grow);
	assign cnt_wa = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign cnt_wd = (state_q == ST_CLEAR) ? '0 : new_cnt;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (accept) begin
			rd_cnt_q <= cnt_mem[set_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			rsp_valid_q    <= 1'b0;
			set_s1         <= '0;
			tag_s1         <= '0;
			opcode_s1      <= 1'b0;
			hit_q          <= 1'b0;
			memory_read_q  <= 1'b0;
			memory_write_q <= 1'b0;
		end else begin
			if (lookup_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						set_s1    <= set_idx;
						tag_s1    <= tag_in;
						opcode_s1 <= opcode;
						state_q   <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (out_free) begin
						hit_q          <= status.hit;
						memory_read_q  <= !status.hit;
						memory_write_q <= (opcode_s1 == OP_WRITE);
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign hit          = hit_q;
	assign memory_read  = memory_read_q;
	assign memory_write = memory_write_q;

endmodule

@@ bench/tag_lookup_sb_pkg.sv @@
// scoreboard package: predicts hit, refill and write-through for each cache access
`timescale 1ns / 100ps

package tag_lookup_sb_pkg;
	import sactr_pkg::*;

	typedef struct packed {
		logic hit;
		logic memory_read;
		logic memory_write;
	} lookup_result_t;

	class lookup_scoreboard;
		logic [DEF_ADDRESS_BITS-1:0] tags [DEF_MAX_SETS*DEF_WAYS];
		bit valid_bits [DEF_MAX_SETS*DEF_WAYS];
		int unsigned offset_bits;
		int unsigned set_bits;
		int unsigned ways_in_use;
		bit policy_lru;
		lookup_result_t pending_results[$];
		int unsigned failures;

		function new();
			foreach (valid_bits[i]) valid_bits[i] = 1'b0;
			offset_bits = RST_OFFSET_BITS;
			set_bits = RST_SET_BITS;
			ways_in_use = RST_WAYS_IN_USE;
			policy_lru = RST_POLICY_LRU;
			failures = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
			case (idx)
				REG_OFFSET_BITS: offset_bits = data[3:0];
				REG_SET_BITS: set_bits = data[2:0];
				REG_WAYS_IN_USE: ways_in_use = data[3:0];
				REG_POLICY_LRU: policy_lru = data[0];
				default: ;
			endcase
		endfunction

		function void note_access(logic op, logic [DEF_ADDRESS_BITS-1:0] addr);
			int unsigned eff_sets;
			int unsigned eff_ways;
			int unsigned fill;
			int unsigned pos;
			int unsigned base;
			logic [63:0] set_idx;
			logic [63:0] line_tag;
			bit found;
			lookup_result_t res;
			eff_sets = set_bits;
			while (eff_sets > 0 && (64'd1 << eff_sets) > DEF_MAX_SETS) eff_sets--;
			eff_ways = (ways_in_use == 0) ? 1 : ways_in_use;
			if (eff_ways > DEF_WAYS) eff_ways = DEF_WAYS;
			set_idx = (64'(addr) >> offset_bits) & ((64'd1 << eff_sets) - 1);
			line_tag = 64'(addr) >> (offset_bits + eff_sets);
			base = int'(set_idx % DEF_MAX_SETS) * DEF_WAYS;
			fill = 0;
			while (fill < eff_ways && valid_bits[base+fill]) fill++;
			found = 1'b0;
			pos = 0;
			for (int j = 0; j < fill; j++) begin
				if (!found && 64'(tags[base+j]) == line_tag) begin
					found = 1'b1;
					pos = j;
				end
			end
			if (found) begin
				if (policy_lru) begin
					for (int j = pos; j + 1 < fill; j++) tags[base+j] = tags[base+j+1];
					tags[base+fill-1] = line_tag[DEF_ADDRESS_BITS-1:0];
				end
			end else if (fill < eff_ways) begin
				tags[base+fill] = line_tag[DEF_ADDRESS_BITS-1:0];
				valid_bits[base+fill] = 1'b1;
			end else begin
				// set full: drop the oldest, newest goes last
				for (int j = 0; j + 1 < eff_ways; j++) tags[base+j] = tags[base+j+1];
				tags[base+eff_ways-1] = line_tag[DEF_ADDRESS_BITS-1:0];
				valid_bits[base+eff_ways-1] = 1'b1;
			end
			res.hit = found;
			res.memory_read = !found;
			res.memory_write = (op == OP_WRITE);
			pending_results.push_back(res);
		endfunction

		function void check_result(logic hit_seen, logic read_seen, logic write_seen);
			lookup_result_t exp_r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result hit %0b memory_read %0b memory_write %0b",
					$time, hit_seen, read_seen, write_seen);
				failures++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (hit_seen !== exp_r.hit) begin
				$display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit_seen);
				failures++;
			end
			if (read_seen !== exp_r.memory_read) begin
				$display("%0t: memory_read expected %0b actual %0b",
					$time, exp_r.memory_read, read_seen);
				failures++;
			end
			if (write_seen !== exp_r.memory_write) begin
				$display("%0t: memory_write expected %0b actual %0b",
					$time, exp_r.memory_write, write_seen);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction
	endclass

endpackage

@@ bench/set_assoc_cache_tag_replacement_unit_tb.sv @@
// testbench top: random and directed cache accesses checked against a tag store predictor
`timescale 1ns / 100ps

module set_assoc_cache_tag_replacement_unit_tb;
	import sactr_pkg::*;
	import tag_lookup_sb_pkg::*;

	localparam int ABITS = DEF_ADDRESS_BITS;
	localparam int N_PHASES = 12;
	localparam int N_FIXED = 8;
	localparam int PHASE_ITEMS = 165;
	localparam int TAIL_CYCLES = 16;
	localparam logic OP_READ = ~OP_WRITE;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	logic opcode = 1'b0;
	logic [ABITS-1:0] address = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic hit;
	logic memory_read;
	logic memory_write;

	lookup_scoreboard sb;
	int unsigned burst_left = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_count = 0;
	logic [ABITS-1:0] tag_pool [12];
	logic [63:0] set_pool [3];
	int unsigned pool_size = 1;
	int unsigned cur_offset = 0;
	int unsigned cur_shift = 0;

	logic [3:0] fixed_offs [N_FIXED] = '{4'd6, 4'd6, 4'd6, 4'd0, 4'd15, 4'd12, 4'd3, 4'd4};
	logic [3:0] fixed_sets [N_FIXED] = '{4'd0, 4'd0, 4'd0, 4'd6, 4'd7, 4'd3, 4'd1, 4'd2};
	logic [3:0] fixed_ways [N_FIXED] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd8, 4'd2, 4'd4};
	logic fixed_lru [N_FIXED] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	set_assoc_cache_tag_replacement_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.opcode(opcode),
		.address(address),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.hit(hit),
		.memory_read(memory_read),
		.memory_write(memory_write)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// receiver stall pattern, changing mode every so often
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_count <= $urandom_range(20, 120);
		end else begin
			rx_count <= rx_count - 1;
		end
		case (rx_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= 1'($urandom_range(0, 1));
			2: rsp_ready <= (rx_count % 4 == 0);
			default: rsp_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(hit, memory_read, memory_write);
	end

	task automatic pause_sender(input int unsigned cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_access(input logic op, input logic [ABITS-1:0] addr);
		req_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		do @(posedge clk); while (!req_ready);
		sb.note_access(op, addr);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			pause_sender($urandom_range(0, 6));
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [3:0] value);
		logic [PDATA_W-1:0] data;
		data = $urandom;
		case (idx)
			REG_SET_BITS: data[2:0] = value[2:0];
			REG_POLICY_LRU: data[0] = value[0];
			default: data[3:0] = value;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input logic [3:0] offs, input logic [3:0] sets,
		input logic [3:0] ways, input logic lru);
		int unsigned eff_s;
		int unsigned eff_w;
		logic [63:0] r;
		drain_results();
		apb_write(REG_OFFSET_BITS, offs);
		apb_write(REG_SET_BITS, sets);
		apb_write(REG_WAYS_IN_USE, ways);
		apb_write(REG_POLICY_LRU, {3'b000, lru});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		eff_s = (sets[2:0] > 6) ? 6 : sets[2:0];
		eff_w = (ways == 0) ? 1 : ((ways > DEF_WAYS) ? DEF_WAYS : ways);
		cur_offset = offs;
		cur_shift = offs + eff_s;
		// a few more tags than ways so that hits and evictions both happen
		pool_size = eff_w + $urandom_range(1, 4);
		for (int k = 0; k < 12; k++) begin
			r = {$urandom, $urandom};
			tag_pool[k] = r[ABITS-1:0];
		end
		for (int k = 0; k < 3; k++) set_pool[k] = $urandom_range(0, (1 << eff_s) - 1);
	endtask

	function automatic logic [ABITS-1:0] pick_address();
		logic [63:0] r;
		logic [63:0] a;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0) return r[ABITS-1:0];
		a = (64'(tag_pool[$urandom_range(0, pool_size - 1)]) << cur_shift)
			| (set_pool[$urandom_range(0, 2)] << cur_offset)
			| (r & ((64'd1 << cur_offset) - 1));
		return a[ABITS-1:0];
	endfunction

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 64-byte blocks, one set, eight ways, lru
		send_access(OP_READ, '0);
		send_access(OP_WRITE, '0);
		send_access(OP_WRITE, '1);
		for (int k = 2; k < 8; k++) send_access(1'(k), ABITS'(k) << 6);
		send_access(OP_READ, '0);
		send_access(OP_WRITE, ABITS'(8) << 6);
		send_access(OP_READ, '1);
		send_access(OP_READ, (ABITS'(2) << 6) | ABITS'(63));
		send_access(OP_WRITE, {1'b1, {(ABITS-1){1'b0}}});
		send_access(OP_READ, ABITS'(63));

		for (int p = 0; p < N_PHASES; p++) begin
			if (p < N_FIXED)
				configure(fixed_offs[p], fixed_sets[p], fixed_ways[p], fixed_lru[p]);
			else
				configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == PHASE_ITEMS / 2) drain_results();
				send_access(1'($urandom_range(0, 1)), pick_address());
			end
		end

		drain_results();
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
